### rtl/sdct_pkg.sv
// Shared types and constants for the SD/MMC SPI-mode card type detection sequencer.
package sdct_pkg;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_CMD0   = 4'd1,
    PH_CMD8   = 4'd2,
    PH_APP_V1 = 4'd3,
    PH_OP_V1  = 4'd4,
    PH_MMC    = 4'd5,
    PH_APP_V2 = 4'd6,
    PH_OP_V2  = 4'd7,
    PH_OCR    = 4'd8
  } phase_t;

  // card type codes
  localparam logic [2:0] T_UNKNOWN = 3'd0;
  localparam logic [2:0] T_NOIDLE  = 3'd1;
  localparam logic [2:0] T_MMC     = 3'd2;
  localparam logic [2:0] T_SD1     = 3'd3;
  localparam logic [2:0] T_SD2     = 3'd4;
  localparam logic [2:0] T_SD2HC   = 3'd5;

  // command indexes
  localparam logic [5:0] CMD_GO_IDLE   = 6'd0;
  localparam logic [5:0] CMD_SEND_OP   = 6'd1;
  localparam logic [5:0] CMD_IF_COND   = 6'd8;
  localparam logic [5:0] CMD_APP_OP    = 6'd41;
  localparam logic [5:0] CMD_APP       = 6'd55;
  localparam logic [5:0] CMD_READ_OCR  = 6'd58;

  // input action codes
  localparam logic ACT_START    = 1'b0;
  localparam logic ACT_RESPONSE = 1'b1;

  localparam logic [31:0] IF_COND_ARG = 32'h0000_01AA;
  localparam logic [31:0] HCS_ARG     = 32'h4000_0000;
  localparam logic [7:0]  R1_ILLEGAL  = 8'h04;
  localparam logic [7:0]  R1_IDLE     = 8'h01;
  localparam logic [7:0]  R1_READY    = 8'h00;
  localparam logic [7:0]  R1_NONE     = 8'hFF;
  localparam logic [7:0]  OCR_CCS     = 8'h40;
  localparam logic [7:0]  IDLE_ATTEMPTS_RST = 8'd255;

  typedef struct packed {
    logic        finished;
    logic [5:0]  command_index;
    logic [31:0] command_argument;
    logic [2:0]  card_type;
  } res_t;

endpackage

### rtl/sdct_seq.sv
// Sequencer state and next-command decision for one start or card response per cycle while step is high.
module sdct_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  logic               action,
  input  logic               responded,
  input  logic [7:0]         first_byte,
  input  logic [7:0]         second_byte,
  input  logic [7:0]         idle_attempts,
  output logic               res_valid,
  output sdct_pkg::res_t     res
);
  import sdct_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [7:0] attempts_r, attempts_nxt;
  logic       ans;
  logic [7:0] r1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      attempts_r <= 8'd0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      attempts_r <= attempts_nxt;
    end
  end

  always_comb begin
    ans          = responded && (first_byte != R1_NONE);
    r1           = first_byte;
    phase_nxt    = phase_r;
    attempts_nxt = attempts_r;
    res_valid    = 1'b1;
    res          = '{finished: 1'b0, command_index: CMD_GO_IDLE,
                     command_argument: 32'd0, card_type: T_UNKNOWN};

    if (action == ACT_START) begin
      attempts_nxt = (idle_attempts == 8'd0) ? 8'd0 : idle_attempts - 8'd1;
      phase_nxt    = PH_CMD0;
    end else begin
      case (phase_r)
        PH_CMD0: begin
          // treat a missing answer as a failed attempt
          if (!ans) r1 = R1_NONE;
          if (r1 == R1_IDLE) begin
            phase_nxt = PH_CMD8;
            res.command_index    = CMD_IF_COND;
            res.command_argument = IF_COND_ARG;
          end else if (attempts_r == 8'd0) begin
            phase_nxt     = PH_IDLE;
            res.finished  = 1'b1;
            res.card_type = (r1 == R1_READY) ? T_NOIDLE : T_UNKNOWN;
          end else begin
            attempts_nxt = attempts_r - 8'd1;
            phase_nxt    = PH_CMD0;
          end
        end
        PH_CMD8: begin
          if (ans && (r1 & R1_ILLEGAL) != 8'd0) begin
            phase_nxt = PH_APP_V1;
            res.command_index = CMD_APP;
          end else if (ans && r1 == R1_IDLE) begin
            phase_nxt = PH_APP_V2;
            res.command_index = CMD_APP;
          end else begin
            phase_nxt    = PH_IDLE;
            res.finished = 1'b1;
          end
        end
        PH_APP_V1: begin
          if (ans) begin
            phase_nxt = PH_OP_V1;
            res.command_index = CMD_APP_OP;
          end else begin
            phase_nxt    = PH_IDLE;
            res.finished = 1'b1;
          end
        end
        PH_OP_V1: begin
          if (ans && (r1 & R1_ILLEGAL) != 8'd0) begin
            phase_nxt = PH_MMC;
            res.command_index = CMD_SEND_OP;
          end else begin
            phase_nxt    = PH_IDLE;
            res.finished = 1'b1;
            if (ans && r1 == R1_IDLE) res.card_type = T_SD1;
          end
        end
        PH_MMC: begin
          if (ans && r1 != R1_READY) begin
            phase_nxt = PH_MMC;
            res.command_index = CMD_SEND_OP;
          end else begin
            phase_nxt    = PH_IDLE;
            res.finished = 1'b1;
            if (ans) res.card_type = T_MMC;
          end
        end
        PH_APP_V2: begin
          if (ans) begin
            phase_nxt = PH_OP_V2;
            res.command_index    = CMD_APP_OP;
            res.command_argument = HCS_ARG;
          end else begin
            phase_nxt    = PH_IDLE;
            res.finished = 1'b1;
          end
        end
        PH_OP_V2: begin
          if (!ans) begin
            phase_nxt    = PH_IDLE;
            res.finished = 1'b1;
          end else if (r1 == R1_READY) begin
            phase_nxt = PH_OCR;
            res.command_index = CMD_READ_OCR;
          end else begin
            phase_nxt = PH_APP_V2;
            res.command_index = CMD_APP;
          end
        end
        PH_OCR: begin
          phase_nxt    = PH_IDLE;
          res.finished = 1'b1;
          if (ans) res.card_type = ((second_byte & OCR_CCS) != 8'd0) ? T_SD2HC : T_SD2;
        end
        default: begin
          // response with no sequence running: drop it
          phase_nxt = PH_IDLE;
          res_valid = 1'b0;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_start_cmd0: assert property (@(posedge clk) disable iff (!rst_n)
    step && action == ACT_START |=> phase_r == PH_CMD0)
    else $error("start did not enter CMD0 phase");

  a_hold_no_step: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(phase_r) && $stable(attempts_r))
    else $error("sequencer state moved without a transfer");

  a_attempts_only_cmd0: assert property (@(posedge clk) disable iff (!rst_n)
    step && action == ACT_RESPONSE && phase_r != PH_CMD0 |=> $stable(attempts_r))
    else $error("attempt count changed outside CMD0 phase");

  a_finish_fields: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.finished |-> res.command_index == CMD_GO_IDLE &&
      res.command_argument == 32'd0 && phase_nxt == PH_IDLE)
    else $error("finish result carries a command");

  a_issue_fields: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res.finished |-> res.card_type == T_UNKNOWN && phase_nxt != PH_IDLE)
    else $error("issued command carries a card type");
`endif

endmodule

### rtl/sd_spi_card_type_detection.sv
// Top level: input register, sequencer, result register and configuration register.
//
// SD/MMC SPI-mode card type detection. Each input transfer is either a start
// (in_tuser = 0) or the card's response to the last command (in_tuser = 1);
// each transfer yields at most one result: the next command to send, or a
// finished flag with the detected card type. A response that arrives while no
// sequence is running yields nothing. The block takes one transfer per cycle
// unless the result side stalls; a result reaches the output through the input
// register, then the result register, and can transfer at the following edge.
// Back-pressure on the result side stalls the input side through in_tready.
// The sequencer state updates once per processed transfer, so consecutive
// responses are handled in order without gaps.
// cfg_wr_data sets the CMD0 attempt count (0 acts as 1); write it only idle.
module sd_spi_card_type_detection (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,   // idle_attempts
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,      // [0] responded, [8:1] first_byte, [16:9] second_byte
  input  logic [0:0]  in_tuser,      // [0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,     // [5:0] command_index, [37:6] command_argument,
                                     // [40:38] card_type
  output logic [0:0]  out_tuser      // [0] finished
);
  import sdct_pkg::*;

  logic [7:0] idle_att_r;
  logic       in_vld_r;
  logic       in_action_r;
  logic       in_resp_r;
  logic [7:0] in_b1_r;
  logic [7:0] in_b2_r;
  logic       out_vld_r;
  res_t       out_res_r;
  logic       fire;
  logic       res_valid;
  res_t       res;

  always_ff @(posedge clk) begin
    if (!rst_n) idle_att_r <= IDLE_ATTEMPTS_RST;
    else if (cfg_wr_en) idle_att_r <= cfg_wr_data;
  end

  // advance the item in the input register when the result slot is free
  assign fire      = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_action_r <= in_tuser[0];
      in_resp_r   <= in_tdata[0];
      in_b1_r     <= in_tdata[8:1];
      in_b2_r     <= in_tdata[16:9];
    end
  end

  sdct_seq u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (fire),
    .action        (in_action_r),
    .responded     (in_resp_r),
    .first_byte    (in_b1_r),
    .second_byte   (in_b2_r),
    .idle_attempts (idle_att_r),
    .res_valid     (res_valid),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire) begin
      out_vld_r <= res_valid;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_valid) out_res_r <= res;
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_res_r.finished;
  assign out_tdata  = {7'd0, out_res_r.card_type, out_res_r.command_argument,
                       out_res_r.command_index};

endmodule
